FILE: src/bast_pkg.sv
// Shared types and constants for the bridge ADC readout block.
// Used by every module under src except bast_div; no dependencies of its own.
`timescale 1ns / 1ps

package bast_pkg;

    // Default build parameters
    localparam int DATA_BITS_DEF    = 24;
    localparam int COUNTER_BITS_DEF = 16;

    // Field widths of the stream payloads
    localparam int ACTION_W    = 2;
    localparam int AVG_W       = 8;
    localparam int STATUS_W    = 2;
    localparam int RAW_W       = 24;
    localparam int NET_OUT_W   = 25;
    localparam int PRESSURE_W  = 40;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 96;

    // Input tdata layout
    localparam int IN_ACT_LSB  = 0;
    localparam int IN_DATA_BIT = 2;
    localparam int IN_AVG_LSB  = 3;

    // Output tdata layout
    localparam int OUT_CLK_BIT  = 0;
    localparam int OUT_RAW_LSB  = 1;
    localparam int OUT_NET_LSB  = 25;
    localparam int OUT_PRES_LSB = 50;
    localparam int OUT_USED_W   = 90;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int HALF_W     = 16;
    localparam int TIMEOUT_W  = 16;
    localparam int TARE_W     = 8;
    localparam int GAP_W      = 16;
    localparam int SENS_W     = 32;
    localparam int SENS_FRAC  = 16;

    localparam logic [HALF_W-1:0]    HALF_PERIOD_RST = 16'd100;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST     = 16'd2000;
    localparam logic [TARE_W-1:0]    TARE_RST        = 8'd20;
    localparam logic [GAP_W-1:0]     GAP_RST         = 16'd0;
    localparam logic [SENS_W-1:0]    SENS_RST        = 32'd0;

    typedef struct packed {
        logic [HALF_W-1:0]    half_period;
        logic [TIMEOUT_W-1:0] ready_timeout;
        logic [TARE_W-1:0]    tare_samples;
        logic [GAP_W-1:0]     sample_gap;
        logic [SENS_W-1:0]    sensitivity;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic step;
        logic div_start;
        logic div_apply;
        logic mul;
        logic scale;
        logic out_load;
    } ctrl_cmd_t;

    // Datapath to controller, valid in the cycle of a step
    typedef struct packed {
        logic need_div;
        logic need_mul;
    } dp_sts_t;

endpackage

FILE: src/bast_regs.sv
// Configuration register file for the bridge ADC readout block.
// Depends on bast_pkg.
`timescale 1ns / 1ps

module bast_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [bast_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [bast_pkg::CFG_DATA_W-1:0] wr_data,
    output bast_pkg::cfg_t                  cfg
);

    typedef enum logic [bast_pkg::CFG_IDX_W-1:0] {
        IDX_HALF_PERIOD = 3'd0,
        IDX_TIMEOUT     = 3'd1,
        IDX_TARE        = 3'd2,
        IDX_GAP         = 3'd3,
        IDX_SENS        = 3'd4
    } cfg_idx_t;

    bast_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_period   <= bast_pkg::HALF_PERIOD_RST;
            cfg_reg.ready_timeout <= bast_pkg::TIMEOUT_RST;
            cfg_reg.tare_samples  <= bast_pkg::TARE_RST;
            cfg_reg.sample_gap    <= bast_pkg::GAP_RST;
            cfg_reg.sensitivity   <= bast_pkg::SENS_RST;
        end else if (wr_en) begin
            case (cfg_idx_t'(wr_index))
                IDX_HALF_PERIOD: cfg_reg.half_period   <= wr_data[bast_pkg::HALF_W-1:0];
                IDX_TIMEOUT:     cfg_reg.ready_timeout <= wr_data[bast_pkg::TIMEOUT_W-1:0];
                IDX_TARE:        cfg_reg.tare_samples  <= wr_data[bast_pkg::TARE_W-1:0];
                IDX_GAP:         cfg_reg.sample_gap    <= wr_data[bast_pkg::GAP_W-1:0];
                IDX_SENS:        cfg_reg.sensitivity   <= wr_data[bast_pkg::SENS_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/bast_div.sv
// Serial restoring divider, signed numerator by unsigned denominator,
// quotient truncated toward zero, one bit per cycle. No package use.
`timescale 1ns / 1ps

module bast_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    busy,
    output logic                    done,
    output logic signed [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] mag_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   rem_sh;
    logic             fits;
    logic [DEN_W:0]   rem_next;

    always_comb begin
        rem_sh   = {rem_reg[DEN_W-1:0], mag_reg[NUM_W-1]};
        fits     = rem_sh >= {1'b0, den_reg};
        rem_next = fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= num[NUM_W-1];
            mag_reg <= num[NUM_W-1] ? (-num) : num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            mag_reg <= {mag_reg[NUM_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = neg_reg ? $signed(-mag_reg) : $signed(mag_reg);

endmodule

FILE: src/bast_dpath.sv
// Datapath: converter line sequencing, read accumulation, offset, scaling
// and the output register. Depends on bast_pkg; drives bast_div operands.
`timescale 1ns / 1ps

module bast_dpath #(
    parameter int DATA_BITS    = bast_pkg::DATA_BITS_DEF,
    parameter int COUNTER_BITS = bast_pkg::COUNTER_BITS_DEF,
    parameter int SUM_W        = DATA_BITS + bast_pkg::AVG_W
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bast_pkg::ctrl_cmd_t               cmd,
    input  bast_pkg::cfg_t                    cfg,
    input  logic [bast_pkg::ACTION_W-1:0]     in_action,
    input  logic                              in_data,
    input  logic [bast_pkg::AVG_W-1:0]        in_avg,
    output bast_pkg::dp_sts_t                 sts,
    output logic signed [SUM_W-1:0]           div_num,
    output logic [bast_pkg::AVG_W-1:0]        div_den,
    input  logic signed [SUM_W-1:0]           div_quot,
    output logic                              out_clk,
    output logic                              out_done,
    output logic [bast_pkg::STATUS_W-1:0]     out_status,
    output logic [bast_pkg::RAW_W-1:0]        out_raw,
    output logic [bast_pkg::NET_OUT_W-1:0]    out_net,
    output logic [bast_pkg::PRESSURE_W-1:0]   out_pressure
);

    localparam int NET_W = DATA_BITS + 1;
    localparam int BC_W  = $clog2(DATA_BITS + 1);
    localparam int CMP_W = (COUNTER_BITS > bast_pkg::HALF_W) ? COUNTER_BITS : bast_pkg::HALF_W;
    localparam int P_W   = NET_W + bast_pkg::SENS_W;
    localparam int SH_W  = P_W - bast_pkg::SENS_FRAC;
    localparam int SAT_W = (SH_W > bast_pkg::PRESSURE_W + 1) ? SH_W : bast_pkg::PRESSURE_W + 1;
    localparam int AW    = bast_pkg::AVG_W;

    localparam logic signed [SAT_W-1:0] LIM_HI =
        SAT_W'((64'sd1 <<< (bast_pkg::PRESSURE_W - 1)) - 64'sd1);
    localparam logic signed [SAT_W-1:0] LIM_LO = -LIM_HI - SAT_W'(1);

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_SINGLE = 2'd1;
    localparam logic [1:0] ACT_TARE   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_READY = 2'd1;
    localparam logic [1:0] ST_NO_READ   = 2'd2;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_WAIT  = 7'b0000010,
        PH_HIGH  = 7'b0000100,
        PH_LOW   = 7'b0001000,
        PH_XHIGH = 7'b0010000,
        PH_XLOW  = 7'b0100000,
        PH_GAP   = 7'b1000000
    } ph_t;

    // sequencer state
    ph_t                     phase_reg,  phase_next;
    logic [1:0]              kind_reg,   kind_next;
    logic [COUNTER_BITS-1:0] tc_reg,     tc_next;
    logic [BC_W-1:0]         bc_reg,     bc_next;
    logic [DATA_BITS-1:0]    sv_reg,     sv_next;
    logic signed [SUM_W-1:0] sum_reg,    sum_next;
    logic [AW-1:0]           rd_reg,     rd_next;
    logic [AW-1:0]           rok_reg,    rok_next;
    logic [AW-1:0]           tgt_reg,    tgt_next;
    logic signed [DATA_BITS-1:0] zero_reg;

    // result payload
    logic signed [NET_W-1:0] net_reg;
    logic signed [P_W-1:0]   prod_reg;
    logic                    res_clk_reg, res_done_reg;
    logic [1:0]              res_status_reg;
    logic [bast_pkg::RAW_W-1:0]      res_raw_reg;
    logic [bast_pkg::NET_OUT_W-1:0]  res_net_reg;
    logic [bast_pkg::PRESSURE_W-1:0] res_pres_reg;

    // output register
    logic                    m_clk_reg, m_done_reg;
    logic [1:0]              m_status_reg;
    logic [bast_pkg::RAW_W-1:0]      m_raw_reg;
    logic [bast_pkg::NET_OUT_W-1:0]  m_net_reg;
    logic [bast_pkg::PRESSURE_W-1:0] m_pres_reg;

    // step logic
    logic                    skip, read_ok, read_fail, rep_ok;
    logic                    o_clk, o_done;
    logic [1:0]              o_status;
    logic [COUNTER_BITS-1:0] tc_inc;
    logic [bast_pkg::HALF_W-1:0] lim;
    logic                    hit;
    logic signed [DATA_BITS-1:0] raw_v;
    logic signed [NET_W-1:0] net_v;
    logic signed [63:0]      raw_x, net_x, mnet_x;
    logic signed [DATA_BITS-1:0] mean;
    logic signed [NET_W-1:0] mnet;
    logic signed [SH_W-1:0]  sh;
    logic signed [SAT_W-1:0] shx;
    logic [bast_pkg::PRESSURE_W-1:0] pres_sat;

    always_comb begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        tc_next    = tc_reg;
        bc_next    = bc_reg;
        sv_next    = sv_reg;
        sum_next   = sum_reg;
        rd_next    = rd_reg;
        rok_next   = rok_reg;
        tgt_next   = tgt_reg;
        skip       = 1'b0;
        read_ok    = 1'b0;
        read_fail  = 1'b0;
        rep_ok     = 1'b0;
        o_clk      = 1'b0;
        o_done     = 1'b0;
        o_status   = ST_OK;
        sts        = '0;

        // request start, only from idle
        if (phase_reg == PH_IDLE && in_action != ACT_TICK) begin
            kind_next = in_action;
            tc_next   = '0;
            bc_next   = '0;
            sv_next   = '0;
            sum_next  = '0;
            rd_next   = '0;
            rok_next  = '0;
            case (in_action)
                ACT_SINGLE: tgt_next = AW'(1);
                ACT_TARE:   tgt_next = cfg.tare_samples;
                default:    tgt_next = in_avg;
            endcase
            if (tgt_next == '0) begin
                o_done   = 1'b1;
                o_status = ST_NO_READ;
                skip     = 1'b1;
            end else begin
                phase_next = PH_WAIT;
            end
        end

        tc_inc = tc_next + 1'b1;
        case (phase_next)
            PH_WAIT: lim = cfg.ready_timeout;
            PH_GAP:  lim = cfg.sample_gap;
            default: lim = cfg.half_period;
        endcase
        hit = CMP_W'(tc_inc) >= CMP_W'(lim);

        if (!skip) begin
            case (phase_next)
                PH_WAIT: begin
                    if (!in_data) begin
                        phase_next = PH_HIGH;
                        tc_next    = '0;
                        bc_next    = '0;
                        sv_next    = '0;
                    end else begin
                        tc_next   = hit ? '0 : tc_inc;
                        read_fail = hit;
                    end
                end
                PH_HIGH: begin
                    o_clk   = 1'b1;
                    tc_next = hit ? '0 : tc_inc;
                    if (hit) begin
                        sv_next    = {sv_next[DATA_BITS-2:0], in_data};
                        bc_next    = bc_next + 1'b1;
                        phase_next = PH_LOW;
                    end
                end
                PH_LOW: begin
                    tc_next = hit ? '0 : tc_inc;
                    if (hit) begin
                        phase_next = (bc_next >= BC_W'(DATA_BITS)) ? PH_XHIGH : PH_HIGH;
                    end
                end
                PH_XHIGH: begin
                    o_clk   = 1'b1;
                    tc_next = hit ? '0 : tc_inc;
                    if (hit) begin
                        phase_next = PH_XLOW;
                    end
                end
                PH_XLOW: begin
                    tc_next = hit ? '0 : tc_inc;
                    read_ok = hit;
                end
                PH_GAP: begin
                    tc_next = hit ? '0 : tc_inc;
                    if (hit) begin
                        phase_next = PH_WAIT;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end

        raw_v = $signed(sv_next);

        // end of one conversion, good or timed out
        if (read_ok || read_fail) begin
            tc_next = '0;
            if (kind_next == ACT_SINGLE) begin
                o_done     = 1'b1;
                phase_next = PH_IDLE;
                if (read_ok) begin
                    rep_ok       = 1'b1;
                    sts.need_mul = 1'b1;
                end else begin
                    o_status = ST_NOT_READY;
                end
            end else begin
                rd_next = rd_next + 1'b1;
                if (read_ok) begin
                    sum_next = sum_next + SUM_W'(raw_v);
                    rok_next = rok_next + 1'b1;
                end
                if (rd_next >= tgt_next) begin
                    o_done     = 1'b1;
                    phase_next = PH_IDLE;
                    if (rok_next == '0) begin
                        o_status = ST_NO_READ;
                    end else begin
                        sts.need_div = 1'b1;
                    end
                end else begin
                    phase_next = (cfg.sample_gap == '0) ? PH_WAIT : PH_GAP;
                end
            end
        end

        net_v = NET_W'(raw_v) - NET_W'(zero_reg);
        raw_x = 64'(raw_v);
        net_x = 64'(net_v);
    end

    // mean of the run and its offset-corrected value
    always_comb begin
        mean   = div_quot[DATA_BITS-1:0];
        mnet   = NET_W'(mean) - NET_W'(zero_reg);
        mnet_x = 64'(mnet);
    end

    // Q16.16 product, floor shift and saturation
    always_comb begin
        sh  = prod_reg[P_W-1:bast_pkg::SENS_FRAC];
        shx = SAT_W'(sh);
        if (shx > LIM_HI) begin
            pres_sat = LIM_HI[bast_pkg::PRESSURE_W-1:0];
        end else if (shx < LIM_LO) begin
            pres_sat = LIM_LO[bast_pkg::PRESSURE_W-1:0];
        end else begin
            pres_sat = shx[bast_pkg::PRESSURE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            kind_reg  <= '0;
            tc_reg    <= '0;
            bc_reg    <= '0;
            sv_reg    <= '0;
            sum_reg   <= '0;
            rd_reg    <= '0;
            rok_reg   <= '0;
            tgt_reg   <= '0;
            zero_reg  <= '0;
        end else begin
            if (cmd.step) begin
                phase_reg <= phase_next;
                kind_reg  <= kind_next;
                tc_reg    <= tc_next;
                bc_reg    <= bc_next;
                sv_reg    <= sv_next;
                sum_reg   <= sum_next;
                rd_reg    <= rd_next;
                rok_reg   <= rok_next;
                tgt_reg   <= tgt_next;
            end
            if (cmd.div_apply && kind_reg == ACT_TARE) begin
                zero_reg <= mean;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            res_clk_reg    <= o_clk;
            res_done_reg   <= o_done;
            res_status_reg <= o_status;
            res_raw_reg    <= rep_ok ? raw_x[bast_pkg::RAW_W-1:0] : '0;
            res_net_reg    <= rep_ok ? net_x[bast_pkg::NET_OUT_W-1:0] : '0;
            res_pres_reg   <= '0;
            net_reg        <= net_v;
        end
        if (cmd.div_apply && kind_reg != ACT_TARE) begin
            res_net_reg <= mnet_x[bast_pkg::NET_OUT_W-1:0];
        end
        if (cmd.mul) begin
            prod_reg <= P_W'(net_reg) * P_W'($signed(cfg.sensitivity));
        end
        if (cmd.scale) begin
            res_pres_reg <= pres_sat;
        end
        if (cmd.out_load) begin
            m_clk_reg    <= res_clk_reg;
            m_done_reg   <= res_done_reg;
            m_status_reg <= res_status_reg;
            m_raw_reg    <= res_raw_reg;
            m_net_reg    <= res_net_reg;
            m_pres_reg   <= res_pres_reg;
        end
    end

    assign div_num      = sum_reg;
    assign div_den      = rok_reg;
    assign out_clk      = m_clk_reg;
    assign out_done     = m_done_reg;
    assign out_status   = m_status_reg;
    assign out_raw      = m_raw_reg;
    assign out_net      = m_net_reg;
    assign out_pressure = m_pres_reg;

endmodule

FILE: src/bast_ctrl.sv
// Controller: sequences one tick through step, divide, multiply, scale and
// output load, and owns the stream handshakes. Depends on bast_pkg.
`timescale 1ns / 1ps

module bast_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  bast_pkg::dp_sts_t   sts,
    input  logic                div_done,
    output bast_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DIV_GO   = 6'b000010,
        S_DIV_WAIT = 6'b000100,
        S_MUL      = 6'b001000,
        S_SCALE    = 6'b010000,
        S_OUT      = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb begin
        cmd           = '0;
        state_next    = state_reg;
        cmd.step      = (state_reg == S_IDLE) && s_tvalid;
        cmd.div_start = (state_reg == S_DIV_GO);
        cmd.div_apply = (state_reg == S_DIV_WAIT) && div_done;
        cmd.mul       = (state_reg == S_MUL);
        cmd.scale     = (state_reg == S_SCALE);
        cmd.out_load  = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (sts.need_div) begin
                        state_next = S_DIV_GO;
                    end else if (sts.need_mul) begin
                        state_next = S_MUL;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_DIV_GO:   state_next = S_DIV_WAIT;
            S_DIV_WAIT: if (div_done) begin
                state_next = S_OUT;
            end
            S_MUL:      state_next = S_SCALE;
            S_SCALE:    state_next = S_OUT;
            S_OUT:      if (cmd.out_load) begin
                state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase

        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

FILE: src/bridge_adc_serial_readout_tare_core.sv
// Top level of the two-wire bridge ADC readout controller with tare.
// Depends on bast_pkg, bast_regs, bast_div, bast_dpath and bast_ctrl.
`timescale 1ns / 1ps

// Usage
//   Each transaction on the s_ channel is one time tick: the request code,
//   the sampled converter data line and a read count for averaged requests.
//   Each tick gives exactly one transaction on the m_ channel: the clock
//   level to drive, a completion flag (tlast), a status code (tuser) and the
//   raw, net and pressure values, which are zero except on a completion.
//   The cfg_ channel writes the timing, tare count, gap and sensitivity
//   registers; it is always ready and is meant to be used while idle.
// Processing
//   A tick that needs no arithmetic has its result registered and then
//   moved to the output register; a completed single read adds the
//   sensitivity multiply and saturating shift; a completed tare or
//   averaged run goes through the serial divider, one quotient bit per
//   cycle. One tick is in flight at a time: another is not accepted until
//   the last has been loaded into the output register.
// Reset and stalls
//   aresetn is synchronous and active low; it returns the registers to their
//   defaults, clears the stored offset and drops any queued result.
//   While the receiver stalls, the finished result waits in the output
//   register; the next tick can be accepted and is processed, then held
//   until the output register is free.

module bridge_adc_serial_readout_tare_core #(
    parameter int DATA_BITS    = bast_pkg::DATA_BITS_DEF,
    parameter int COUNTER_BITS = bast_pkg::COUNTER_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // tick input; tdata from bit 0: action[1:0], data_level, avg_samples[7:0], zero fill
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bast_pkg::S_TDATA_W-1:0]  s_tdata,
    // result; tdata from bit 0: clk_level, raw_value[23:0], net_value[24:0],
    // pressure[39:0], zero fill
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bast_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast,  // done_res
    output logic [bast_pkg::STATUS_W-1:0]   m_tuser,  // status[1:0]
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bast_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bast_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int SUM_W = DATA_BITS + bast_pkg::AVG_W;

    bast_pkg::cfg_t      cfg;
    bast_pkg::ctrl_cmd_t cmd;
    bast_pkg::dp_sts_t   sts;

    logic signed [SUM_W-1:0]         div_num;
    logic [bast_pkg::AVG_W-1:0]      div_den;
    logic signed [SUM_W-1:0]         div_quot;
    logic                            div_busy;
    logic                            div_done;

    logic                            out_clk;
    logic                            out_done;
    logic [bast_pkg::STATUS_W-1:0]   out_status;
    logic [bast_pkg::RAW_W-1:0]      out_raw;
    logic [bast_pkg::NET_OUT_W-1:0]  out_net;
    logic [bast_pkg::PRESSURE_W-1:0] out_pressure;

    assign cfg_ready = 1'b1;

    bast_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // shared divider for the run mean
    bast_div #(
        .NUM_W (SUM_W),
        .DEN_W (bast_pkg::AVG_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    bast_dpath #(
        .DATA_BITS    (DATA_BITS),
        .COUNTER_BITS (COUNTER_BITS),
        .SUM_W        (SUM_W)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .cfg          (cfg),
        .in_action    (s_tdata[bast_pkg::IN_ACT_LSB +: bast_pkg::ACTION_W]),
        .in_data      (s_tdata[bast_pkg::IN_DATA_BIT]),
        .in_avg       (s_tdata[bast_pkg::IN_AVG_LSB +: bast_pkg::AVG_W]),
        .sts          (sts),
        .div_num      (div_num),
        .div_den      (div_den),
        .div_quot     (div_quot),
        .out_clk      (out_clk),
        .out_done     (out_done),
        .out_status   (out_status),
        .out_raw      (out_raw),
        .out_net      (out_net),
        .out_pressure (out_pressure)
    );

    bast_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .div_done (div_done),
        .cmd      (cmd)
    );

    // pack the result fields, lowest first
    always_comb begin
        m_tdata = '0;
        m_tdata[bast_pkg::OUT_CLK_BIT]                             = out_clk;
        m_tdata[bast_pkg::OUT_RAW_LSB  +: bast_pkg::RAW_W]         = out_raw;
        m_tdata[bast_pkg::OUT_NET_LSB  +: bast_pkg::NET_OUT_W]     = out_net;
        m_tdata[bast_pkg::OUT_PRES_LSB +: bast_pkg::PRESSURE_W]    = out_pressure;
    end

    assign m_tlast = out_done;
    assign m_tuser = out_status;

`ifndef SYNTHESIS
    // one tick in flight: the controller leaves idle on every acceptance
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("tick accepted while another was still in progress");

    // a fresh result only comes from the output-load state, never from idle
    a_load_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result raised without a tick being processed");

    // the divider is never restarted while it is still iterating
    a_div_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !div_busy)
        else $error("divider restarted while busy");
`endif

endmodule

FILE: verif/tb_bridge_adc_serial_readout_tare_core.sv
// Self-checking bench for the bridge ADC readout core: tick stream in, one result per tick out.
// Depends on bast_pkg and bridge_adc_serial_readout_tare_core; runs standalone.
`timescale 1ns / 1ps

module tb_bridge_adc_serial_readout_tare_core;
    import bast_pkg::*;

    localparam int NBITS = DATA_BITS_DEF;

    typedef enum bit [1:0] {ACT_TICK, ACT_READ, ACT_TARE, ACT_AVG} action_e;
    typedef enum bit [1:0] {ST_OK, ST_NOT_READY, ST_NO_READ} status_e;
    typedef enum bit [2:0] {REG_HALF, REG_TIMEOUT, REG_TARE, REG_GAP, REG_SENS} reg_e;
    typedef enum bit [2:0] {
        PH_IDLE, PH_WAIT, PH_HIGH, PH_LOW, PH_XHIGH, PH_XLOW, PH_GAP
    } phase_e;

    // One tick's worth of output; logic so that X on the bus is caught
    typedef struct {
        logic                  clk;
        logic                  done;
        logic [STATUS_W-1:0]   status;
        logic [RAW_W-1:0]      raw;
        logic [NET_OUT_W-1:0]  net;
        logic [PRESSURE_W-1:0] pres;
    } result_t;

    // ------------------------------------------------------------------
    // Readout predictor: shadows the registers and controller state,
    // works out the result of each accepted tick and checks the outputs
    // in order.
    // ------------------------------------------------------------------
    class readout_scoreboard;
        bit [HALF_W-1:0]        half_period;
        bit [TIMEOUT_W-1:0]     ready_timeout;
        bit [TARE_W-1:0]        tare_count;
        bit [GAP_W-1:0]         gap_ticks;
        bit signed [SENS_W-1:0] sens;

        phase_e         phase;
        action_e        kind;
        bit [15:0]      tick_cnt;
        bit [5:0]       bits_in;
        bit [NBITS-1:0] shreg;
        longint         sum;
        bit [7:0]       done_cnt;
        bit [7:0]       ok_cnt;
        bit [7:0]       target;
        longint         offset;

        result_t cur;
        result_t pending[$];
        int      errors;
        int      completions;

        function new();
            half_period   = HALF_PERIOD_RST;
            ready_timeout = TIMEOUT_RST;
            tare_count    = TARE_RST;
            gap_ticks     = GAP_RST;
            sens          = SENS_RST;
            phase         = PH_IDLE;
            kind          = ACT_TICK;
            tick_cnt      = 0;
            bits_in       = 0;
            shreg         = 0;
            sum           = 0;
            done_cnt      = 0;
            ok_cnt        = 0;
            target        = 0;
            offset        = 0;
            errors        = 0;
            completions   = 0;
        endfunction

        function void set_register(reg_e idx, bit [CFG_DATA_W-1:0] val);
            case (idx)
                REG_HALF:    half_period   = val[HALF_W-1:0];
                REG_TIMEOUT: ready_timeout = val[TIMEOUT_W-1:0];
                REG_TARE:    tare_count    = val[TARE_W-1:0];
                REG_GAP:     gap_ticks     = val[GAP_W-1:0];
                REG_SENS:    sens          = val[SENS_W-1:0];
                default: ;
            endcase
        endfunction

        // a limit of zero behaves as one
        function bit count_up(bit [15:0] lim);
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= lim) begin
                tick_cnt = 0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // floor of net * sens / 2^16, clamped to 40-bit signed
        function longint pressure_of(longint net);
            longint prod;
            longint r;
            longint lim;
            lim  = longint'(1) << (PRESSURE_W - 1);
            prod = net * longint'(sens);
            r    = prod >>> SENS_FRAC;
            if (r > lim - 1) r = lim - 1;
            if (r < -lim) r = -lim;
            return r;
        endfunction

        function void end_run();
            longint mean;
            cur.done = 1'b1;
            if (ok_cnt == 0) begin
                cur.status = ST_NO_READ;
            end else begin
                mean = sum / longint'(ok_cnt);   // truncates toward zero
                if (kind == ACT_TARE) offset = mean;
                else cur.net = mean - offset;
            end
            phase = PH_IDLE;
        endfunction

        function void end_read(bit ok);
            longint raw;
            longint net;
            raw = $signed(shreg);
            tick_cnt = 0;
            if (kind == ACT_READ) begin
                cur.done = 1'b1;
                if (ok) begin
                    net      = raw - offset;
                    cur.raw  = raw;
                    cur.net  = net;
                    cur.pres = pressure_of(net);
                end else begin
                    cur.status = ST_NOT_READY;
                end
                phase = PH_IDLE;
                return;
            end
            done_cnt = done_cnt + 1'b1;
            if (ok) begin
                sum    = sum + raw;
                ok_cnt = ok_cnt + 1'b1;
            end
            if (done_cnt >= target) end_run();
            else phase = (gap_ticks == 0) ? PH_WAIT : PH_GAP;
        endfunction

        function void take_tick(action_e act, bit data, bit [7:0] avg);
            cur = '{default: '0};
            if (phase == PH_IDLE && act != ACT_TICK) begin
                kind     = act;
                tick_cnt = 0;
                bits_in  = 0;
                shreg    = 0;
                sum      = 0;
                done_cnt = 0;
                ok_cnt   = 0;
                target   = (act == ACT_READ) ? 8'd1 : (act == ACT_TARE) ? tare_count : avg;
                if (target == 0) begin
                    end_run();
                end else begin
                    phase = PH_WAIT;
                end
            end
            if (!cur.done) begin
                case (phase)
                    PH_WAIT: begin
                        // data is tested on the very tick the request is taken
                        if (!data) begin
                            phase    = PH_HIGH;
                            tick_cnt = 0;
                            bits_in  = 0;
                            shreg    = 0;
                        end else if (count_up(ready_timeout)) begin
                            end_read(1'b0);
                        end
                    end
                    PH_HIGH: begin
                        cur.clk = 1'b1;
                        if (count_up(half_period)) begin
                            shreg   = {shreg[NBITS-2:0], data};
                            bits_in = bits_in + 1'b1;
                            phase   = PH_LOW;
                        end
                    end
                    PH_LOW: begin
                        if (count_up(half_period))
                            phase = (bits_in >= NBITS) ? PH_XHIGH : PH_HIGH;
                    end
                    PH_XHIGH: begin
                        cur.clk = 1'b1;
                        if (count_up(half_period)) phase = PH_XLOW;
                    end
                    PH_XLOW: begin
                        if (count_up(half_period)) end_read(1'b1);
                    end
                    PH_GAP: begin
                        if (count_up(gap_ticks)) phase = PH_WAIT;
                    end
                    default: ;
                endcase
            end
            if (cur.done) completions++;
            pending.push_back(cur);
        endfunction

        function void report(string field, logic [63:0] want_v, logic [63:0] got_v);
            if (want_v !== got_v) begin
                errors++;
                if (errors <= 50)
                    $display("%0t: %s mismatch: expected %0h actual %0h",
                             $time, field, want_v, got_v);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 50)
                    $display("%0t: unexpected result: expected none actual %p", $time, got);
                return;
            end
            want = pending.pop_front();
            report("clk_level", want.clk, got.clk);
            report("done_res", want.done, got.done);
            report("status", want.status, got.status);
            report("raw_value", want.raw, got.raw);
            report("net_value", want.net, got.net);
            report("pressure", want.pres, got.pres);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT and its signals; every input starts at a known level
    // ------------------------------------------------------------------
    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic [STATUS_W-1:0]    m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    readout_scoreboard sb = new();

    bit calm       = 1'b0;   // final stretch: no idling on either side
    bit src_gappy  = 1'b1;   // sender inserts idle bursts while set
    int ticks_sent = 0;
    int rx_left    = 0;
    bit rx_stall   = 1'b0;

    bridge_adc_serial_readout_tare_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // action[1:0], data_level, avg_samples[7:0], zero fill
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // clk_level, raw[23:0], net[24:0], pressure[39:0], fill
        .m_tlast   (m_tlast),    // done_res
        .m_tuser   (m_tuser),    // status[1:0]
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case a transaction never completes
    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    // Receiver: ready stretches and stall bursts in random order and length
    always @(posedge aclk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (rx_left > 0) begin
            rx_left = rx_left - 1;
        end else begin
            rx_stall = ($urandom_range(0, 2) == 0);
            rx_left  = rx_stall ? $urandom_range(0, 7) : $urandom_range(0, 15);
            m_tready <= !rx_stall;
        end
    end

    // Output monitor: every accepted result transaction is checked in order
    always @(posedge aclk) begin : result_monitor
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.clk    = m_tdata[OUT_CLK_BIT];
            got.done   = m_tlast;
            got.status = m_tuser;
            got.raw    = m_tdata[OUT_RAW_LSB +: RAW_W];
            got.net    = m_tdata[OUT_NET_LSB +: NET_OUT_W];
            got.pres   = m_tdata[OUT_PRES_LSB +: PRESSURE_W];
            sb.check_result(got);
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One tick transaction; tvalid stays high into the next call unless
    // an idle burst is taken here.
    task automatic send_tick(action_e act, bit data, bit [7:0] avg);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[IN_ACT_LSB +: ACTION_W] = act;
        word[IN_DATA_BIT]            = data;
        word[IN_AVG_LSB +: AVG_W]    = avg;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        sb.take_tick(act, data, avg);
        ticks_sent++;
        if (!calm && src_gappy && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    // Runs one request to completion. The data line follows what the
    // converter would do: while waiting it goes low with low_pct percent
    // chance per tick (0 = never ready), during a high half it carries the
    // current bit of v0/v1 (alternating per read) or noise.
    task automatic run_request(action_e act, bit [7:0] avg, int low_pct,
                               bit [NBITS-1:0] v0, bit [NBITS-1:0] v1, bit rand_bits);
        bit             data;
        bit             first;
        bit [NBITS-1:0] v;
        first = 1'b1;
        do begin
            v = sb.done_cnt[0] ? v1 : v0;
            if (first || sb.phase == PH_WAIT)
                data = ($urandom_range(1, 100) > low_pct);
            else if (sb.phase == PH_HIGH)
                data = rand_bits ? 1'($urandom_range(0, 1)) : v[NBITS-1-sb.bits_in];
            else
                data = $urandom_range(0, 1);
            // while busy the action and count are ignored, so they carry noise
            if (first) send_tick(act, data, avg);
            else send_tick(action_e'($urandom_range(0, 3)), data, $urandom_range(0, 255));
            first = 1'b0;
        end while (sb.phase != PH_IDLE);
    endtask

    // Waits until every expected result is out, then for the divider's
    // worst-case latency so the core is truly quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (NBITS + 16) @(posedge aclk);
    endtask

    task automatic write_register(reg_e idx, bit [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_register(idx, val);
    endtask

    task automatic configure(bit [15:0] half, bit [15:0] timeout, bit [7:0] tare,
                             bit [15:0] gap, bit [31:0] sens_q16);
        settle();
        write_register(REG_HALF, half);
        write_register(REG_TIMEOUT, timeout);
        write_register(REG_TARE, tare);
        write_register(REG_GAP, gap);
        write_register(REG_SENS, sens_q16);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int      blk;
        int      base_done;
        int      base_sent;
        int      pick;
        action_e act;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: plain ticks, then an averaged read of zero reads
        send_tick(ACT_TICK, 1'b0, 8'h00);
        send_tick(ACT_TICK, 1'b1, 8'hFF);
        run_request(ACT_AVG, 8'd0, 100, '0, '0, 1'b0);

        // Fast clock, short timeout, two-read tare with gaps, unity scale
        configure(16'd1, 16'd4, 8'd2, 16'd3, 32'h0001_0000);
        run_request(ACT_READ, 8'd0, 100, 24'h123456, 24'h123456, 1'b0);
        run_request(ACT_READ, 8'd0, 0, '0, '0, 1'b0);                     // not ready
        run_request(ACT_TARE, 8'd0, 100, 24'h000100, 24'h000300, 1'b0);   // offset 0x200
        run_request(ACT_READ, 8'd0, 100, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
        run_request(ACT_AVG, 8'd2, 100, 24'hFFFFFD, 24'hFFFFFC, 1'b0);     // negative mean
        run_request(ACT_AVG, 8'd3, 0, '0, '0, 1'b0);                      // no success
        run_request(ACT_TARE, 8'd0, 0, '0, '0, 1'b0);                     // offset kept
        run_request(ACT_AVG, 8'd0, 100, '0, '0, 1'b0);                    // zero count

        // Zero half period and timeout act as one; tare count of zero; scale -1.0
        configure(16'd0, 16'd0, 8'd0, 16'd0, 32'hFFFF_0000);
        run_request(ACT_TARE, 8'd0, 100, '0, '0, 1'b0);
        run_request(ACT_READ, 8'd0, 100, 24'h000000, 24'h000000, 1'b0);
        run_request(ACT_READ, 8'd0, 100, 24'hFFFFFF, 24'hFFFFFF, 1'b0);

        // Longest timeout and gap (no gap after the last read), largest scale
        configure(16'd1, 16'hFFFF, 8'd1, 16'hFFFF, 32'h7FFF_FFFF);
        run_request(ACT_TARE, 8'd0, 100, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
        run_request(ACT_READ, 8'd0, 100, 24'h800000, 24'h800000, 1'b0);   // widest net
        run_request(ACT_AVG, 8'd1, 100, 24'h000001, 24'h000001, 1'b0);

        // Most negative scale on the widest net
        configure(16'd2, 16'hFFFF, 8'd1, 16'hFFFF, 32'h8000_0000);
        run_request(ACT_READ, 8'd0, 100, 24'h800000, 24'h800000, 1'b0);

        // Longest half period: only plain ticks are sent, no read
        configure(16'hFFFF, 16'hFFFF, 8'd1, 16'hFFFF, 32'h8000_0000);
        send_tick(ACT_TICK, 1'b0, 8'h55);
        send_tick(ACT_TICK, 1'b1, 8'hAA);

        // Largest run counts against a converter that never answers
        configure(16'd1, 16'd1, 8'd255, 16'd0, 32'h0000_8000);
        run_request(ACT_TARE, 8'd0, 0, '0, '0, 1'b0);
        run_request(ACT_AVG, 8'd255, 0, '0, '0, 1'b0);

        // Random part: mostly well-formed conversions with random content,
        // plus timeouts, plain ticks and noise on the data line. The last
        // block runs without idling.
        for (blk = 0; blk < 3; blk++) begin
            configure(($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 2)),
                      $urandom_range(0, 12), $urandom_range(1, 3), $urandom_range(0, 4),
                      (blk == 0) ? 32'h8000_0000 : $urandom);
            calm      = (blk == 2);
            base_done = sb.completions;
            base_sent = ticks_sent;
            while (sb.completions - base_done < 12 || ticks_sent - base_sent < 130) begin
                src_gappy = $urandom_range(0, 1);
                pick      = $urandom_range(0, 9);
                if (pick < 2) begin
                    send_tick(ACT_TICK, $urandom_range(0, 1), $urandom_range(0, 255));
                end else begin
                    act = (pick < 5) ? ACT_READ : (pick < 7) ? ACT_TARE : ACT_AVG;
                    run_request(act,
                                (act != ACT_AVG) ? 8'($urandom_range(0, 255)) :
                                ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 8)) :
                                8'($urandom_range(0, 4)),
                                ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(20, 100),
                                $urandom, $urandom, $urandom_range(0, 9) < 7);
                end
            end
        end

        settle();
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
